// ===== hdl/lvp_pkg.sv =====
// ----------------------------------------------------------------------------
// lvp_pkg
// Curve constants and segment tables for the lipo voltage to percent block:
// 17-point discharge curve, per-segment lower point, percent step and span.
// ----------------------------------------------------------------------------
package lvp_pkg;

	localparam int MvW      = 16;
	localparam int PctW     = 7;
	localparam int SegCount = 16;
	localparam int SegW     = $clog2(SegCount);
	localparam int OffW     = 7;
	localparam int DpW      = 4;
	localparam int NumW     = 10;
	localparam int RecipW   = 11;
	localparam int DivW     = 8;
	localparam int QuotW    = 4;
	localparam int RecipShift = 16;

	localparam logic [MvW-1:0]  TopMv    = 16'd4200;
	localparam logic [MvW-1:0]  BottomMv = 16'd3400;
	localparam logic [PctW-1:0] FullPct  = 7'd100;
	localparam logic [PctW-1:0] EmptyPct = 7'd0;

	typedef enum logic [1:0] {
		SPAN_30,
		SPAN_40,
		SPAN_50,
		SPAN_100
	} span_t;

	typedef struct packed {
		logic [NumW-1:0] num;
		span_t           span;
		logic [PctW-1:0] lo_pct;
	} div_req_t;

	function automatic logic [MvW-1:0] seg_lo_mv(input logic [SegW-1:0] seg);
		logic [MvW-1:0] r;
		case (seg)
			4'd0:    r = 16'd4150;
			4'd1:    r = 16'd4110;
			4'd2:    r = 16'd4080;
			4'd3:    r = 16'd4050;
			4'd4:    r = 16'd4000;
			4'd5:    r = 16'd3950;
			4'd6:    r = 16'd3900;
			4'd7:    r = 16'd3850;
			4'd8:    r = 16'd3800;
			4'd9:    r = 16'd3750;
			4'd10:   r = 16'd3700;
			4'd11:   r = 16'd3650;
			4'd12:   r = 16'd3600;
			4'd13:   r = 16'd3550;
			4'd14:   r = 16'd3500;
			default: r = 16'd3400;
		endcase
		return r;
	endfunction

	function automatic logic [PctW-1:0] seg_lo_pct(input logic [SegW-1:0] seg);
		logic [PctW-1:0] r;
		case (seg)
			4'd0:    r = 7'd97;
			4'd1:    r = 7'd93;
			4'd2:    r = 7'd89;
			4'd3:    r = 7'd85;
			4'd4:    r = 7'd79;
			4'd5:    r = 7'd72;
			4'd6:    r = 7'd64;
			4'd7:    r = 7'd55;
			4'd8:    r = 7'd46;
			4'd9:    r = 7'd37;
			4'd10:   r = 7'd28;
			4'd11:   r = 7'd20;
			4'd12:   r = 7'd13;
			4'd13:   r = 7'd7;
			4'd14:   r = 7'd3;
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DpW-1:0] seg_dp(input logic [SegW-1:0] seg);
		logic [DpW-1:0] r;
		case (seg)
			4'd0:    r = 4'd3;
			4'd1:    r = 4'd4;
			4'd2:    r = 4'd4;
			4'd3:    r = 4'd4;
			4'd4:    r = 4'd6;
			4'd5:    r = 4'd7;
			4'd6:    r = 4'd8;
			4'd7:    r = 4'd9;
			4'd8:    r = 4'd9;
			4'd9:    r = 4'd9;
			4'd10:   r = 4'd9;
			4'd11:   r = 4'd8;
			4'd12:   r = 4'd7;
			4'd13:   r = 4'd6;
			4'd14:   r = 4'd4;
			default: r = 4'd3;
		endcase
		return r;
	endfunction

	function automatic span_t seg_span(input logic [SegW-1:0] seg);
		span_t r;
		case (seg)
			4'd1:    r = SPAN_40;
			4'd2:    r = SPAN_30;
			4'd3:    r = SPAN_30;
			4'd15:   r = SPAN_100;
			default: r = SPAN_50;
		endcase
		return r;
	endfunction

	function automatic logic [DivW-1:0] span_mv(input span_t s);
		logic [DivW-1:0] r;
		case (s)
			SPAN_30:  r = 8'd30;
			SPAN_40:  r = 8'd40;
			SPAN_50:  r = 8'd50;
			SPAN_100: r = 8'd100;
			default:  r = 8'd50;
		endcase
		return r;
	endfunction

	// divisor is twice the span
	function automatic logic [DivW-1:0] span_div(input span_t s);
		logic [DivW-1:0] r;
		case (s)
			SPAN_30:  r = 8'd60;
			SPAN_40:  r = 8'd80;
			SPAN_50:  r = 8'd100;
			SPAN_100: r = 8'd200;
			default:  r = 8'd100;
		endcase
		return r;
	endfunction

	// floor(2^16 / divisor)
	function automatic logic [RecipW-1:0] span_recip(input span_t s);
		logic [RecipW-1:0] r;
		case (s)
			SPAN_30:  r = 11'd1092;
			SPAN_40:  r = 11'd819;
			SPAN_50:  r = 11'd655;
			SPAN_100: r = 11'd327;
			default:  r = 11'd655;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/lvp_div.sv =====
// ----------------------------------------------------------------------------
// lvp_div
// Two-stage constant divide: reciprocal multiply estimate, then one
// remainder check that corrects the quotient and adds the segment base.
// ----------------------------------------------------------------------------
module lvp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  lvp_pkg::div_req_t             req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [lvp_pkg::PctW-1:0]      percent
);
	import lvp_pkg::*;

	logic                        valid_s4;
	logic                        valid_s5;
	logic                        rdy_s4;
	logic                        rdy_s5;
	logic [QuotW-1:0]            q0_s4;
	logic [NumW-1:0]             num_s4;
	span_t                       span_s4;
	logic [PctW-1:0]             lo_pct_s4;
	logic [PctW-1:0]             percent_s5;

	logic [NumW+RecipW-1:0]      prod;
	logic [QuotW+DivW-1:0]       qd;
	logic [QuotW+DivW-1:0]       rem;
	logic [DivW-1:0]             dv;
	logic                        inc;

	assign rdy_s5    = !valid_s5 || rsp_ready;
	assign rdy_s4    = !valid_s4 || rdy_s5;
	assign req_ready = rdy_s4;

	assign prod = NumW'(req.num) * span_recip(req.span);

	assign dv  = span_div(span_s4);
	assign qd  = q0_s4 * dv;
	assign rem = (QuotW+DivW)'(num_s4) - qd;
	assign inc = rem >= (QuotW+DivW)'(dv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s4) valid_s4 <= req_valid;
			if (rdy_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			q0_s4     <= prod[RecipShift +: QuotW];
			num_s4    <= req.num;
			span_s4   <= req.span;
			lo_pct_s4 <= req.lo_pct;
		end
		if (rdy_s5) begin
			percent_s5 <= lo_pct_s4 + PctW'(q0_s4) + PctW'(inc);
		end
	end

	assign rsp_valid = valid_s5;
	assign percent   = percent_s5;

endmodule

// ===== hdl/lipo_voltage_to_percent.sv =====
// ----------------------------------------------------------------------------
// lipo_voltage_to_percent
// Single-cell lipo state of charge from battery millivolts, by linear
// interpolation on a 17-point discharge curve, rounded half up.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------
//  input    | in_valid / in_ready  | millivolts[15:0] unsigned
//  output   | out_valid / out_ready| percent[6:0] unsigned, 0..100
//
//  five register stages: segment search, offset, numerator, reciprocal
//  multiply, correct and add; one word per cycle while out_ready is high
//  the stage chain sets the rate; each stage holds while the next is full
//  arst_n clears the valid bits only
//  a stall at out_ready backs up stage by stage, nothing lost or repeated
// ----------------------------------------------------------------------------
module lipo_voltage_to_percent (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [lvp_pkg::MvW-1:0]   millivolts,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [lvp_pkg::PctW-1:0]  percent
);
	import lvp_pkg::*;

	logic              valid_s1, valid_s2, valid_s3;
	logic              rdy_s1, rdy_s2, rdy_s3;
	logic              div_ready;

	logic [SegW-1:0]   seg_s1;
	logic [MvW-1:0]    mv_s1;
	logic              hi_s1, lo_s1;

	logic [OffW-1:0]   off_s2;
	logic [DpW-1:0]    dp_s2;
	span_t             span_s2;
	logic [PctW-1:0]   lo_pct_s2;

	div_req_t          req_s3;

	logic [SegW-1:0]   seg_hit;
	logic [MvW-1:0]    mv_diff;
	logic [NumW-1:0]   num;

	assign rdy_s3   = !valid_s3 || div_ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// first segment from the top whose lower point is reached
	always_comb begin
		seg_hit = SegW'(SegCount - 1);
		for (int i = SegCount - 1; i >= 0; i--) begin
			if (millivolts >= seg_lo_mv(SegW'(i))) seg_hit = SegW'(i);
		end
	end

	assign mv_diff = mv_s1 - seg_lo_mv(seg_s1);
	assign num     = NumW'({off_s2, 1'b0}) * NumW'(dp_s2) + NumW'(span_mv(span_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			seg_s1 <= seg_hit;
			mv_s1  <= millivolts;
			hi_s1  <= millivolts >= TopMv;
			lo_s1  <= millivolts <= BottomMv;
		end
		if (rdy_s2) begin
			span_s2 <= seg_span(seg_s1);
			if (hi_s1 || lo_s1) begin
				off_s2    <= '0;
				dp_s2     <= '0;
				lo_pct_s2 <= hi_s1 ? FullPct : EmptyPct;
			end else begin
				off_s2    <= mv_diff[OffW-1:0];
				dp_s2     <= seg_dp(seg_s1);
				lo_pct_s2 <= seg_lo_pct(seg_s1);
			end
		end
		if (rdy_s3) begin
			req_s3.num    <= num;
			req_s3.span   <= span_s2;
			req_s3.lo_pct <= lo_pct_s2;
		end
	end

	lvp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (valid_s3),
		.req_ready (div_ready),
		.req       (req_s3),
		.rsp_valid (out_valid),
		.rsp_ready (out_ready),
		.percent   (percent)
	);

	// result never exceeds a full charge
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> percent <= FullPct)
		else $error("percent above full charge");

	// a free output lets the whole chain advance
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled with output free");

	// a clamped word carries no interpolation step
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rdy_s2 && (hi_s1 || lo_s1) |=> dp_s2 == '0 && off_s2 == '0)
		else $error("clamped word carries a step");

endmodule
